/* hw/rtl/i2cee_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cee_pkg
// Shared codes, defaults and types of the serial EEPROM slave core.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int MEM_DEPTH_DEFAULT = 256;
  localparam logic [6:0] DEV_ADDR_RESET = 7'd80;

  localparam logic [7:0] REPLY_ACK  = 8'd1;
  localparam logic [7:0] REPLY_NONE = 8'd0;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_RSTART = 3'd1,
    OP_STOP   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // Access request from the bus engine to the byte store.
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

/* hw/rtl/i2c_eeprom_slave_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_slave_core
// Byte-level I2C slave of a small serial EEPROM, driven by bus events.
// ----------------------------------------------------------------------------
// Each input word is one bus event: in_tuser carries the event code (start,
// repeated start, stop, master writes byte, master reads byte) and in_tdata
// the byte written by the master. Every event produces exactly one reply word
// on the out_ channel: 1 for an ack, 0 for a nak or no answer, or the data
// byte for a read.
// The block takes one event per cycle while the receiver keeps up. A reply
// passes the read stage, which holds the synchronous byte store read, and then
// the output register. The store is read and written at the word pointer in
// the cycle of acceptance, so a read that directly follows a write to the
// same byte already sees the new data.
// Two result slots (the read stage and the output register) decouple the
// sides; when the receiver stalls, in_tready drops once both are full.
// Reset clears the transaction flags, the pointer and the valid bit of every
// byte, so the whole store reads as erased (0xFF) at once; the device
// address returns to 80. cfg_we writes the device address register.
// ----------------------------------------------------------------------------
module i2c_eeprom_slave_core #(
  parameter int MEM_DEPTH = i2cee_pkg::MEM_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,    // device_address
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,     // [7:0] bus_byte
  input  logic [2:0] in_tuser,     // [2:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata     // [7:0] reply
);

  localparam int PW = $clog2(MEM_DEPTH);

  logic [6:0]    dev_r;
  logic          in_tr_r, in_tr_nxt;
  logic          as_r, as_nxt;
  logic          sel_r, sel_nxt;
  logic          rm_r, rm_nxt;
  logic          ps_r, ps_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;

  logic          s1_v_r, s1_rd_r;
  logic [7:0]    s1_reply_r;
  logic [7:0]    reply_nxt;
  logic          out_v_r;
  logic [7:0]    out_data_r;

  logic          in_fire, s1_go;
  i2cee_pkg::mem_ctl_t mem_ctl;
  logic [7:0]    mem_rdata;
  logic [PW-1:0] ptr_inc, ptr_load;
  logic [11:0]   rem;

  assign s1_go     = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  assign ptr_inc = (ptr_r == PW'(MEM_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  // Byte modulo depth by restoring subtraction; the depth must be at least 16
  // (the block does not check this), so four steps cover any byte value.
  always_comb begin
    rem = {4'd0, in_tdata};
    for (int k = 3; k >= 0; k--) begin
      if (rem >= (12'(MEM_DEPTH) << k)) begin
        rem = rem - (12'(MEM_DEPTH) << k);
      end
    end
  end
  assign ptr_load = rem[PW-1:0];

  always_comb begin
    in_tr_nxt = in_tr_r;
    as_nxt    = as_r;
    sel_nxt   = sel_r;
    rm_nxt    = rm_r;
    ps_nxt    = ps_r;
    ptr_nxt   = ptr_r;
    reply_nxt = i2cee_pkg::REPLY_NONE;
    mem_ctl   = '0;
    if (in_fire) begin
      case (in_tuser)
        i2cee_pkg::OP_START: begin
          in_tr_nxt = 1'b1;
          ps_nxt    = 1'b0;
          as_nxt    = 1'b0;
          sel_nxt   = 1'b0;
        end
        i2cee_pkg::OP_RSTART: begin
          as_nxt  = 1'b0;
          sel_nxt = 1'b0;
        end
        i2cee_pkg::OP_STOP: begin
          in_tr_nxt = 1'b0;
        end
        i2cee_pkg::OP_WRITE: begin
          if (in_tr_r) begin
            if (!as_r) begin
              as_nxt = 1'b1;
              if (in_tdata[7:1] == dev_r) begin
                sel_nxt   = 1'b1;
                rm_nxt    = in_tdata[0];
                reply_nxt = i2cee_pkg::REPLY_ACK;
              end
            end else if (sel_r && !rm_r) begin
              reply_nxt = i2cee_pkg::REPLY_ACK;
              if (!ps_r) begin
                ps_nxt  = 1'b1;
                ptr_nxt = ptr_load;
              end else begin
                mem_ctl.wr = 1'b1;
                ptr_nxt    = ptr_inc;
              end
            end
          end
        end
        i2cee_pkg::OP_READ: begin
          if (in_tr_r && as_r && sel_r && rm_r && ps_r) begin
            mem_ctl.rd = 1'b1;
            ptr_nxt    = ptr_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= i2cee_pkg::DEV_ADDR_RESET;
      in_tr_r <= 1'b0;
      as_r    <= 1'b0;
      sel_r   <= 1'b0;
      rm_r    <= 1'b0;
      ps_r    <= 1'b0;
      ptr_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        dev_r <= cfg_wdata;
      end
      in_tr_r <= in_tr_nxt;
      as_r    <= as_nxt;
      sel_r   <= sel_nxt;
      rm_r    <= rm_nxt;
      ps_r    <= ps_nxt;
      ptr_r   <= ptr_nxt;
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r    <= mem_ctl.rd;
      s1_reply_r <= reply_nxt;
    end
    if (s1_go) begin
      out_data_r <= s1_rd_r ? mem_rdata : s1_reply_r;
    end
  end

  i2cee_mem #(
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mem_ctl),
    .addr (ptr_r),
    .wdata(in_tdata),
    .rdata(mem_rdata)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_rd_needs_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.rd |-> (ps_r && rm_r && sel_r && as_r && in_tr_r))
    else $error("store read issued without a selected read transaction");

  a_wr_acks: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr |=> (s1_v_r && !s1_rd_r && s1_reply_r == i2cee_pkg::REPLY_ACK))
    else $error("store write not answered with an ack");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_reply_r) && $stable(s1_rd_r)))
    else $error("pending reply overwritten while output stalled");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == i2cee_pkg::OP_START) |=> (in_tr_r && !as_r && !sel_r && !ps_r))
    else $error("start did not reset transaction flags");

endmodule

/* hw/rtl/i2cee_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cee_mem
// Byte store with one shared address, registered read and per-entry valid bits
// so that unwritten bytes read as erased.
// ----------------------------------------------------------------------------
module i2cee_mem #(
  parameter int DEPTH = i2cee_pkg::MEM_DEPTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  i2cee_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      addr,
  input  logic [7:0]         wdata,
  output logic [7:0]         rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (ctl.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd) begin
        q_vld_r <= vld_r[addr];
      end
    end
  end

  assign rdata = q_vld_r ? q_r : i2cee_pkg::ERASED_BYTE;

endmodule
